>>> hdl/ghs_pkg.sv
// Shared types, constants and helpers for the GGX Hammersley sample direction pipeline.
`timescale 1ns / 1ps
package ghs_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam logic [29:0] CORDIC_K30 = 30'd652032874;

   // arctangent of 2^-i in turns, Q0.32
   localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
      30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
      30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
      30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
      30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
   };

   // m^4 for a 4-bit mip level
   localparam logic [15:0] POW4 [16] = '{
      16'd0, 16'd1, 16'd16, 16'd81, 16'd256, 16'd625, 16'd1296, 16'd2401,
      16'd4096, 16'd6561, 16'd10000, 16'd14641, 16'd20736, 16'd28561, 16'd38416, 16'd50625
   };

   // phase lookup tables indexed by 5 bits of the sample index
   typedef logic [31:0] phase_quo_type [32];
   typedef logic [16:0] phase_rem_type [32];

   typedef struct packed {
      logic [9:0]         idx;
      logic [3:0]         mip;
      logic [26:0]        aa;
      logic [26:0]        bb;
      logic [26:0]        dd;
      logic [27:0]        rem;
      logic [31:0]        quo;
      logic               bzero;
      logic [31:0]        pq;
      logic [49:0]        radc;
      logic [49:0]        rads;
      logic [28:0]        rc;
      logic [28:0]        rs;
      logic [24:0]        qc;
      logic [24:0]        qs;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [32:0] z;
      logic [1:0]         quad;
   } stage_type;

   // Q0.30 signed value to biased unorm16: floor((2^30 + c + 2^14) / 2^15), clamped
   function automatic logic [15:0] to_unorm16(input logic signed [33:0] c);
      logic signed [35:0] s;
      logic signed [35:0] t;
      s = 36'sd1073741824 + 36'(c) + 36'sd16384;
      t = s >>> 15;
      if (t < 36'sd0) begin
         return 16'd0;
      end else if (t > 36'sd65535) begin
         return 16'hFFFF;
      end
      return t[15:0];
   endfunction

endpackage

>>> hdl/ghs_if.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface ghs_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] sample_index;
   logic [3:0] mip_level;
   modport source (output valid, output sample_index, output mip_level, input ready);
   modport sink (input valid, input sample_index, input mip_level, output ready);
endinterface

interface ghs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] dir_x;
   logic [15:0] dir_y;
   logic [15:0] dir_z;
   modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
   modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

>>> hdl/ggx_hammersley_sample_dir.sv
// GGX importance-sample half vector from a Hammersley point, fully pipelined.
//
//   channel   dir  handshake        payload
//   req_if    in   valid/ready      sample_index[9:0], mip_level[3:0]
//   rsp_if    out  valid/ready      dir_x[15:0], dir_y[15:0], dir_z[15:0]
//
// One item per cycle while the response side does not stall.
// Depth is set by the 32-step cos^2 divider, the 25-step square roots and the
// 24-step rotation CORDIC, one step per stage.
// Synchronous reset clears the stage valid bits and the output and skid valid bits.
// A stalled response fills the skid register; the pipeline then halts as a whole.
`timescale 1ns / 1ps
module ggx_hammersley_sample_dir
   import ghs_pkg::*;
#(
   parameter int NUM_SAMPLES    = 1024,
   parameter int NUM_MIP_LEVELS = 5
) (
   input  logic      clock,
   input  logic      reset,
   ghs_req_if.sink   req_if,
   ghs_rsp_if.source rsp_if
);

   // floor(k * step * 2^32 / NUM_SAMPLES) mod 2^32 and the matching remainder
   function automatic phase_quo_type phase_quo_tab(input longint unsigned step);
      phase_quo_type t;
      for (int k = 0; k < 32; k++) begin
         t[k] = 32'(((64'(k) * step) << 32) / 64'(NUM_SAMPLES));
      end
      return t;
   endfunction

   function automatic phase_rem_type phase_rem_tab(input longint unsigned step);
      phase_rem_type t;
      for (int k = 0; k < 32; k++) begin
         t[k] = 17'(((64'(k) * step) << 32) % 64'(NUM_SAMPLES));
      end
      return t;
   endfunction

   localparam int LMAX_I = NUM_MIP_LEVELS - 1;
   localparam logic [3:0]  LMAX = LMAX_I[3:0];
   localparam int DEN_I = LMAX_I * LMAX_I * LMAX_I * LMAX_I;
   localparam logic [15:0] DEN = DEN_I[15:0];
   localparam logic [16:0] NS = NUM_SAMPLES[16:0];

   localparam phase_quo_type PQ_LO = phase_quo_tab(64'd1);
   localparam phase_quo_type PQ_HI = phase_quo_tab(64'd32);
   localparam phase_rem_type PR_LO = phase_rem_tab(64'd1);
   localparam phase_rem_type PR_HI = phase_rem_tab(64'd32);

   localparam int S_MUL   = 1;
   localparam int S_SUM   = 2;
   localparam int S_DIV   = 3;
   localparam int S_PREP  = S_DIV + 32;
   localparam int S_SQRT  = S_PREP + 1;
   localparam int S_GAIN  = S_SQRT + 25;
   localparam int S_ROT   = S_GAIN + 1;
   localparam int LAST    = S_ROT + CORDIC_STEPS - 1;
   localparam int NSTG    = LAST + 1;

   stage_type  st_ff [NSTG];
   stage_type  st_in [NSTG];
   logic [NSTG-1:0] v_ff;

   logic        adv;
   logic        take;
   logic        push;
   logic        out_v_ff;
   logic        skid_v_ff;
   logic [15:0] ox_ff, oy_ff, oz_ff;
   logic [15:0] sx_ff, sy_ff, sz_ff;
   logic [15:0] nx, ny, nz;

   assign adv         = !skid_v_ff;
   assign req_if.ready = adv;
   assign take        = rsp_if.valid && rsp_if.ready;
   assign push        = adv && v_ff[LAST];

   // input stage
   always_comb begin
      st_in[0]       = '0;
      st_in[0].idx   = req_if.sample_index;
      st_in[0].mip   = (req_if.mip_level > LMAX) ? LMAX : req_if.mip_level;
   end

   for (genvar s = 1; s < NSTG; s++) begin : g_stage
      always_comb begin : comb
         stage_type  n;
         logic [9:0]  vr;
         logic [27:0] r2;
         logic [17:0] psum;
         logic [32:0] c2;
         logic [28:0] tc, ts, rc2, rs2;
         logic [54:0] prod;
         logic signed [33:0] dx, dy;
         logic signed [32:0] at;
         n = st_ff[s-1];
         vr = '0; r2 = '0; psum = '0; c2 = '0; tc = '0; ts = '0; rc2 = '0; rs2 = '0;
         prod = '0; dx = '0; dy = '0; at = '0;
         if (s == S_MUL) begin
            for (int k = 0; k < 10; k++) begin
               vr[9-k] = n.idx[k];
            end
            n.aa = 27'(DEN) * 27'(11'd1024 - {1'b0, vr});
            n.bb = 27'(POW4[n.mip]) * 27'(vr);
            // phase = idx * 2^32 / NUM_SAMPLES from two table halves plus carry
            psum = {1'b0, PR_LO[n.idx[4:0]]} + {1'b0, PR_HI[n.idx[9:5]]};
            n.pq = PQ_LO[n.idx[4:0]] + PQ_HI[n.idx[9:5]] + {31'b0, (psum >= {1'b0, NS})};
         end
         if (s == S_SUM) begin
            n.dd    = n.aa + n.bb;
            n.rem   = {1'b0, n.aa};
            n.bzero = (n.bb == '0);
            n.quo   = '0;
         end
         if (s >= S_DIV && s < S_PREP) begin
            r2 = {n.rem[26:0], 1'b0};
            if (r2 >= {1'b0, n.dd}) begin
               n.rem = r2 - {1'b0, n.dd};
               n.quo = {n.quo[30:0], 1'b1};
            end else begin
               n.rem = r2;
               n.quo = {n.quo[30:0], 1'b0};
            end
         end
         if (s == S_PREP) begin
            c2     = n.bzero ? 33'h1_0000_0000 : {1'b0, n.quo};
            n.radc = {1'b0, c2, 16'b0};
            n.rads = {1'b0, 33'h1_0000_0000 - c2, 16'b0};
            n.rc   = '0;
            n.rs   = '0;
            n.qc   = '0;
            n.qs   = '0;
         end
         if (s >= S_SQRT && s < S_GAIN) begin
            rc2 = {n.rc[26:0], n.radc[49-2*(s-S_SQRT) -: 2]};
            rs2 = {n.rs[26:0], n.rads[49-2*(s-S_SQRT) -: 2]};
            tc  = {2'b0, n.qc, 2'b01};
            ts  = {2'b0, n.qs, 2'b01};
            if (rc2 >= tc) begin
               n.rc = rc2 - tc;
               n.qc = {n.qc[23:0], 1'b1};
            end else begin
               n.rc = rc2;
               n.qc = {n.qc[23:0], 1'b0};
            end
            if (rs2 >= ts) begin
               n.rs = rs2 - ts;
               n.qs = {n.qs[23:0], 1'b1};
            end else begin
               n.rs = rs2;
               n.qs = {n.qs[23:0], 1'b0};
            end
         end
         if (s == S_GAIN) begin
            prod   = {30'b0, n.qs} * {25'b0, CORDIC_K30};
            n.x    = {3'b0, prod[54:24]};
            n.y    = '0;
            n.z    = {3'b0, n.pq[29:0]};
            n.quad = n.pq[31:30];
         end
         if (s >= S_ROT) begin
            dx = n.y >>> (s - S_ROT);
            dy = n.x >>> (s - S_ROT);
            at = {3'b0, ATAN_TURN[s-S_ROT]};
            if (!n.z[32]) begin
               n.x = n.x - dx;
               n.y = n.y + dy;
               n.z = n.z - at;
            end else begin
               n.x = n.x + dx;
               n.y = n.y - dy;
               n.z = n.z + at;
            end
         end
         st_in[s] = n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSTG-2:0], req_if.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < NSTG; s++) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   // quadrant fold and unorm mapping
   always_comb begin
      logic signed [33:0] cx, cy;
      unique case (st_ff[LAST].quad)
         2'd0: begin cx = st_ff[LAST].x;  cy = st_ff[LAST].y;  end
         2'd1: begin cx = -st_ff[LAST].y; cy = st_ff[LAST].x;  end
         2'd2: begin cx = -st_ff[LAST].x; cy = -st_ff[LAST].y; end
         default: begin cx = st_ff[LAST].y; cy = -st_ff[LAST].x; end
      endcase
      nx = to_unorm16(cx);
      ny = to_unorm16(cy);
      nz = to_unorm16({3'b0, st_ff[LAST].qc, 6'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_v_ff && !take) begin
            skid_v_ff <= 1'b1;
         end
         out_v_ff <= 1'b1;
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take) begin
            ox_ff <= sx_ff;
            oy_ff <= sy_ff;
            oz_ff <= sz_ff;
         end
      end else if (push) begin
         if (out_v_ff && !take) begin
            sx_ff <= nx;
            sy_ff <= ny;
            sz_ff <= nz;
         end else begin
            ox_ff <= nx;
            oy_ff <= ny;
            oz_ff <= nz;
         end
      end
   end

   assign rsp_if.valid = out_v_ff;
   assign rsp_if.dir_x = ox_ff;
   assign rsp_if.dir_y = oy_ff;
   assign rsp_if.dir_z = oz_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff) else $error("skid holds an item while output is empty");

   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> $stable(v_ff) || !$past(skid_v_ff))
      else $error("pipeline moved while halted");

   a_z_upper: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.dir_z[15]) else $error("dir_z below one half");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      push && out_v_ff && !take |=> skid_v_ff) else $error("item dropped at output");

endmodule
